// ===== sv/ecit_pkg.sv =====
// ----------------------------------------------------------------------------
// ecit_pkg
// Types, codes and constants shared by the interval timer modules.
// ----------------------------------------------------------------------------
package ecit_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_sel;

    localparam t_op  OP_TICK  = 2'd0;
    localparam t_op  OP_READ  = 2'd1;
    localparam t_op  OP_WRITE = 2'd2;

    localparam t_sel SEL_DIV  = 2'd0;
    localparam t_sel SEL_TIMA = 2'd1;
    localparam t_sel SEL_TMA  = 2'd2;
    localparam t_sel SEL_TAC  = 2'd3;

    localparam logic [7:0] TAC_READ_FILL  = 8'hF8;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [2:0] RELOAD_DELAY   = 3'd4;
    localparam int         TAC_ENABLE_BIT = 2;
    localparam int         APU_BIT_NORMAL = 12;
    localparam int         APU_BIT_DOUBLE = 13;

    typedef struct packed {
        t_op        op;
        t_sel       reg_select;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_interrupt;
        logic       apu_tick;
    } t_result;

    // Divider bit watched by the counter for each clock select code
    function automatic logic [3:0] tap_bit(input logic [1:0] clk_sel);
        logic [3:0] bit_idx;
        case (clk_sel)
            2'd0: bit_idx = 4'd9;
            2'd1: bit_idx = 4'd3;
            2'd2: bit_idx = 4'd5;
            2'd3: bit_idx = 4'd7;
            default: bit_idx = 4'd9;
        endcase
        return bit_idx;
    endfunction

    function automatic logic timer_signal(input logic [15:0] div, input logic [2:0] ctl);
        return ctl[TAC_ENABLE_BIT] & div[tap_bit(ctl[1:0])];
    endfunction

endpackage

// ===== sv/ecit_core.sv =====
// ----------------------------------------------------------------------------
// ecit_core
// Timer state (divider, counter, modulo, control, reload delay) and the
// combinational update for one item, registered when the item fires.
// ----------------------------------------------------------------------------
module ecit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ecit_pkg::t_item   i_item,
    input  logic              i_double_speed,
    output ecit_pkg::t_result o_result
);
    import ecit_pkg::*;

    logic [15:0] r_div,    n_div;
    logic [7:0]  r_count,  n_count;
    logic [7:0]  r_modulo, n_modulo;
    logic [2:0]  r_ctl,    n_ctl;
    logic [2:0]  r_wait,   n_wait;

    logic        old_t;
    logic        new_t;
    logic        old_a;
    logic        new_a;
    logic        bump;
    logic [7:0]  cnt_mid;
    t_result     res;

    always_comb begin
        n_div    = r_div;
        n_count  = r_count;
        n_modulo = r_modulo;
        n_ctl    = r_ctl;
        n_wait   = r_wait;
        res      = '0;
        bump     = 1'b0;
        old_t    = timer_signal(r_div, r_ctl);
        old_a    = i_double_speed ? r_div[APU_BIT_DOUBLE] : r_div[APU_BIT_NORMAL];
        new_t    = 1'b0;
        new_a    = 1'b0;

        case (i_item.op)
            OP_TICK: begin
                if (r_wait != 3'd0) begin
                    n_wait = r_wait - 3'd1;
                    if (n_wait == 3'd0) begin
                        n_count             = r_modulo;
                        res.timer_interrupt = 1'b1;
                    end
                end
                n_div = r_div + 16'd1;
                new_t = timer_signal(n_div, r_ctl);
                new_a = i_double_speed ? n_div[APU_BIT_DOUBLE] : n_div[APU_BIT_NORMAL];
                bump  = old_t & ~new_t;
                res.apu_tick = old_a & ~new_a;
            end
            OP_READ: begin
                case (i_item.reg_select)
                    SEL_DIV:  res.read_data = r_div[15:8];
                    SEL_TIMA: res.read_data = r_count;
                    SEL_TMA:  res.read_data = r_modulo;
                    SEL_TAC:  res.read_data = {5'd0, r_ctl} | TAC_READ_FILL;
                    default:  res.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_select)
                    SEL_DIV: begin
                        n_div        = '0;
                        bump         = old_t;
                        res.apu_tick = old_a;
                    end
                    SEL_TIMA: begin
                        n_count = i_item.write_data;
                        n_wait  = 3'd0;
                    end
                    SEL_TMA: begin
                        n_modulo = i_item.write_data;
                    end
                    SEL_TAC: begin
                        n_ctl = i_item.write_data[2:0];
                        new_t = timer_signal(r_div, n_ctl);
                        bump  = old_t & ~new_t;
                    end
                    default: begin
                        n_ctl = r_ctl;
                    end
                endcase
            end
            default: begin
                res = '0;
            end
        endcase

        // Counter increment, ignored while a reload is pending
        cnt_mid = n_count;
        if (bump && (n_wait == 3'd0)) begin
            if (cnt_mid == COUNT_MAX) begin
                n_count = '0;
                n_wait  = RELOAD_DELAY;
            end else begin
                n_count = cnt_mid + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= '0;
            r_count  <= '0;
            r_modulo <= '0;
            r_ctl    <= '0;
            r_wait   <= '0;
        end else if (i_fire) begin
            r_div    <= n_div;
            r_count  <= n_count;
            r_modulo <= n_modulo;
            r_ctl    <= n_ctl;
            r_wait   <= n_wait;
        end
    end

    assign o_result = res;

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait <= RELOAD_DELAY)
        else $error("reload delay out of range");

    a_wait_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != 3'd0) |-> (r_count == 8'd0))
        else $error("counter not held at zero during reload delay");

    a_irq_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.timer_interrupt) |-> (i_item.op == OP_TICK && r_wait == 3'd1))
        else $error("interrupt outside the end of a reload delay");

    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_TICK) |=> (r_div == $past(r_div) + 16'd1))
        else $error("divider did not advance on tick");

endmodule

// ===== sv/edge_clocked_interval_timer.sv =====
// ----------------------------------------------------------------------------
// edge_clocked_interval_timer
// Divider / counter / modulo / control interval timer, one item per cycle while not stalled.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid with i_op, i_reg_select, i_write_data; the block
// drives o_in_stall. Each item is a tick, a register read or a register write.
// Output channel: o_out_valid with o_read_data, o_timer_interrupt and
// o_apu_tick; the receiver drives i_out_stall. Every item gives one result.
// An accepted item sits in the input register, is processed by the core and
// lands in the output register, where the result is offered. The block takes
// one item per cycle while the receiver does not stall, since the core
// updates its state as each item fires.
// When the receiver stalls, the result holds, the input register holds its
// item and o_in_stall rises while that register is full; nothing is lost.
// i_cfg_we with i_cfg_data sets double speed (audio pulse from divider bit
// 13 instead of 12); write it only while the block is idle.
// Synchronous active-low reset clears divider, counter, modulo, control,
// reload delay, double speed and both valid flags.
// ----------------------------------------------------------------------------
module edge_clocked_interval_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [1:0] i_reg_select,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_timer_interrupt,
    output logic       o_apu_tick,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    import ecit_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    logic    r_double_speed;
    logic    advance;
    logic    in_accept;
    t_result core_result;

    assign advance    = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_in_valid & ~advance;
    assign in_accept  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_double_speed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_double_speed <= i_cfg_data;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= '{op: i_op, reg_select: i_reg_select, write_data: i_write_data};
        end
        if (advance && r_in_valid) begin
            r_result <= core_result;
        end
    end

    ecit_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (r_in_valid & advance),
        .i_item         (r_item),
        .i_double_speed (r_double_speed),
        .o_result       (core_result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_result.read_data;
    assign o_timer_interrupt = r_result.timer_interrupt;
    assign o_apu_tick        = r_result.apu_tick;

endmodule

// ===== tb/tb_edge_clocked_interval_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_clocked_interval_timer
// Self-checking bench for the divider / counter / modulo / control timer.
// A short table of directed items runs first: reset values, register extremes,
// overflow by select change, an increment during a pending reload, the delayed
// reload and its cancellation. Random items follow in four phases, alternating
// double speed. Results are checked against an in-bench timer model, or the
// table on typed rows. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_edge_clocked_interval_timer;

    import ecit_pkg::*;

    localparam t_op        OP_UNUSED        = 2'd3;
    localparam logic [1:0] TAC_SEL_FAST     = 2'd1;
    localparam int         DIR_ROWS         = 19;
    localparam int         RANDOM_PER_PHASE = 350;
    localparam int         PHASES           = 4;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         STALL_NONE       = 0;
    localparam int         STALL_LIGHT      = 1;
    localparam int         STALL_BEAT       = 2;
    localparam int         STALL_HEAVY      = 3;

    typedef struct packed {
        t_item      item;
        logic [5:0] times;
        logic       typed;
        t_result    res;
    } t_dir_row;

    // typed = 1: expected result taken from the row, not from the model
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{'{OP_READ,   SEL_TAC,  8'h00}, 6'd1, 1'b1, '{TAC_READ_FILL, 1'b0, 1'b0}},
        '{'{OP_READ,   SEL_DIV,  8'h00}, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TMA,  8'hFF}, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_READ,   SEL_TMA,  8'h00}, 6'd1, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'hFF}, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_READ,   SEL_TAC,  8'h00}, 6'd1, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'h05}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TIMA, 8'hFF}, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_TICK,   SEL_DIV,  8'h00}, 6'd8, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'h06}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'h05}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'h06}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_TICK,   SEL_DIV,  8'h00}, 6'd4, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_READ,   SEL_TIMA, 8'h00}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TAC,  8'h05}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_DIV,  8'hA5}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_WRITE,  SEL_TIMA, 8'h00}, 6'd1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_TICK,   SEL_DIV,  8'h00}, 6'd4, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{'{OP_UNUSED, SEL_TAC,  8'hFF}, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0}}
    };

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_op              = OP_TICK;
    logic [1:0] i_reg_select      = SEL_DIV;
    logic [7:0] i_write_data      = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall       = 1'b0;
    logic [7:0] o_read_data;
    logic       o_timer_interrupt;
    logic       o_apu_tick;
    logic       i_cfg_we          = 1'b0;
    logic       i_cfg_data        = 1'b0;

    // timer model state
    logic [15:0] div_acc;
    logic [7:0]  tima_val;
    logic [7:0]  tma_val;
    logic [2:0]  tac_val;
    logic [2:0]  reload_left;
    logic        apu_double;

    t_result     expected_results [$];
    t_result     head;
    int          mismatches   = 0;
    int          burst_left   = 0;
    int unsigned cycle_no     = 0;
    int unsigned stall_mode   = STALL_NONE;
    int unsigned stall_period = 4;
    int          idle_cycles  = 0;

    edge_clocked_interval_timer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_reg_select      (i_reg_select),
        .i_write_data      (i_write_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_read_data       (o_read_data),
        .o_timer_interrupt (o_timer_interrupt),
        .o_apu_tick        (o_apu_tick),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic tima_clock_level();
        int unsigned tap;
        case (tac_val[1:0])
            2'd0:    tap = 9;
            2'd1:    tap = 3;
            2'd2:    tap = 5;
            default: tap = 7;
        endcase
        return tac_val[TAC_ENABLE_BIT] & div_acc[tap];
    endfunction

    function automatic logic apu_clock_level();
        return apu_double ? div_acc[APU_BIT_DOUBLE] : div_acc[APU_BIT_NORMAL];
    endfunction

    function automatic void tima_increment();
        if (reload_left == 3'd0) begin
            if (tima_val == COUNT_MAX) begin
                tima_val    = 8'h00;
                reload_left = RELOAD_DELAY;
            end else begin
                tima_val = tima_val + 8'd1;
            end
        end
    endfunction

    function automatic t_result predict_timer_result(input t_item it);
        t_result r;
        logic    tima_was;
        logic    apu_was;
        r = '0;
        case (it.op)
            OP_TICK: begin
                if (reload_left != 3'd0) begin
                    reload_left = reload_left - 3'd1;
                    if (reload_left == 3'd0) begin
                        tima_val          = tma_val;
                        r.timer_interrupt = 1'b1;
                    end
                end
                tima_was = tima_clock_level();
                apu_was  = apu_clock_level();
                div_acc  = div_acc + 16'd1;
                if (tima_was && !tima_clock_level()) tima_increment();
                if (apu_was && !apu_clock_level()) r.apu_tick = 1'b1;
            end
            OP_READ: begin
                case (it.reg_select)
                    SEL_DIV:  r.read_data = div_acc[15:8];
                    SEL_TIMA: r.read_data = tima_val;
                    SEL_TMA:  r.read_data = tma_val;
                    default:  r.read_data = {5'd0, tac_val} | TAC_READ_FILL;
                endcase
            end
            OP_WRITE: begin
                case (it.reg_select)
                    SEL_DIV: begin
                        tima_was = tima_clock_level();
                        apu_was  = apu_clock_level();
                        div_acc  = 16'd0;
                        if (tima_was && !tima_clock_level()) tima_increment();
                        if (apu_was) r.apu_tick = 1'b1;
                    end
                    SEL_TIMA: begin
                        tima_val    = it.write_data;
                        reload_left = 3'd0;
                    end
                    SEL_TMA: tma_val = it.write_data;
                    default: begin
                        tima_was = tima_clock_level();
                        tac_val  = it.write_data[2:0];
                        if (tima_was && !tima_clock_level()) tima_increment();
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        it.reg_select = t_sel'($urandom_range(0, 3));
        it.write_data = 8'($urandom_range(0, 255));
        if (pick < 58) begin
            it.op = OP_TICK;
        end else if (pick < 78) begin
            it.op = OP_READ;
        end else if (pick < 97) begin
            it.op = OP_WRITE;
            pick  = $urandom_range(0, 99);
            if (pick < 8) begin
                it.reg_select = SEL_DIV;
            end else if (pick < 48) begin
                // near the top so overflow comes often
                it.reg_select = SEL_TIMA;
                if ($urandom_range(0, 1) == 0) it.write_data[7:3] = 5'h1F;
            end else if (pick < 70) begin
                it.reg_select = SEL_TMA;
            end else begin
                it.reg_select = SEL_TAC;
                if ($urandom_range(0, 4) != 0) it.write_data[TAC_ENABLE_BIT] = 1'b1;
                if ($urandom_range(0, 1) == 0) it.write_data[1:0] = TAC_SEL_FAST;
            end
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic offer_item(input t_item it, input logic typed, input t_result typed_res);
        t_result     calc;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 32);
        end
        i_in_valid   <= 1'b1;
        i_op         <= it.op;
        i_reg_select <= it.reg_select;
        i_write_data <= it.write_data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        calc = predict_timer_result(it);
        expected_results.push_back(typed ? typed_res : calc);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic apply_speed_mode(input logic value);
        wait_all_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apu_double = value;
    endtask

    initial begin
        div_acc     = 16'd0;
        tima_val    = 8'h00;
        tma_val     = 8'h00;
        tac_val     = 3'd0;
        reload_left = 3'd0;
        apu_double  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            repeat (DIRECTED_ROWS[r].times)
                offer_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_speed_mode(ph[0] ? 1'b0 : 1'b1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(0, 149) == 0) wait_all_results();
                offer_item(random_item(), 1'b0, '0);
            end
        end

        wait_all_results();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: read_data %02h", o_read_data);
                    mismatches++;
                end else begin
                    head = expected_results.pop_front();
                    if (o_read_data !== head.read_data) begin
                        $error("read_data: expected %02h, got %02h",
                               head.read_data, o_read_data);
                        mismatches++;
                    end
                    if (o_timer_interrupt !== head.timer_interrupt) begin
                        $error("timer_interrupt: expected %0b, got %0b",
                               head.timer_interrupt, o_timer_interrupt);
                        mismatches++;
                    end
                    if (o_apu_tick !== head.apu_tick) begin
                        $error("apu_tick: expected %0b, got %0b", head.apu_tick, o_apu_tick);
                        mismatches++;
                    end
                end
            end
            cycle_no++;
            if (cycle_no % 256 == 0) begin
                stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
                stall_period = $urandom_range(2, 8);
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_BEAT:  i_out_stall <= ((cycle_no % stall_period) < (stall_period / 2));
                default:     i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
